### rtl/cht_pkg.sv
// cht_pkg: types, codes and constants for the hold-tap block.
// No dependencies.
`timescale 1ns / 1ps
package cht_pkg;

  localparam int POSITIONS_DEF = 16;
  localparam int MAX_RESULTS   = 32;
  localparam int ADDR_W        = 4;

  localparam logic [15:0] TERM_RST     = 16'd200;
  localparam logic [15:0] GRACE_RST    = 16'd40;
  localparam logic [15:0] COOLDOWN_RST = 16'd30;
  localparam logic [15:0] DURATION_RST = 16'd10;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_HOLD    = 2'd2,
    ST_GRACE   = 2'd3
  } key_st_t;

  typedef enum logic [2:0] {
    K_LAYER_ON    = 3'd0,
    K_LAYER_OFF   = 3'd1,
    K_KEY_PRESS   = 3'd2,
    K_KEY_RELEASE = 3'd3,
    K_REJECT      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_TERM     = 2'd0,
    REG_GRACE    = 2'd1,
    REG_COOLDOWN = 2'd2,
    REG_DURATION = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_KEY,
    SQ_REL,
    SQ_HOLD,
    SQ_EMIT
  } seq_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  position;
    logic [7:0]  layer;
    logic [31:0] keycode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot;
    logic [7:0]  layer_out;
    logic [31:0] keycode_out;
    logic [31:0] stamp;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] term;
    logic [15:0] grace;
    logic [15:0] cooldown;
    logic [15:0] duration;
  } cfg_t;

endpackage

### rtl/cht_regs.sv
// cht_regs: APB register file for the four timing registers.
// Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [cht_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output cht_pkg::cfg_t         cfg
);
  import cht_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.term     <= TERM_RST;
      cfg.grace    <= GRACE_RST;
      cfg.cooldown <= COOLDOWN_RST;
      cfg.duration <= DURATION_RST;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_TERM:     cfg.term     <= pwdata[15:0];
        REG_GRACE:    cfg.grace    <= pwdata[15:0];
        REG_COOLDOWN: cfg.cooldown <= pwdata[15:0];
        REG_DURATION: cfg.duration <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_TERM:     prdata = {16'd0, cfg.term};
        REG_GRACE:    prdata = {16'd0, cfg.grace};
        REG_COOLDOWN: prdata = {16'd0, cfg.cooldown};
        REG_DURATION: prdata = {16'd0, cfg.duration};
        default:      prdata = '0;
      endcase
    end
  end
endmodule

### rtl/cht_core.sv
// cht_core: slot state table and the sequencer that walks it one slot at a time.
// Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_core #(
  parameter int POSITIONS = cht_pkg::POSITIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cht_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  cht_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cht_pkg::out_item_t out_item
);
  import cht_pkg::*;

  localparam int SW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);

  // per-slot state
  key_st_t     key_state [POSITIONS];
  logic [7:0]  bound_layer [POSITIONS];
  logic [31:0] bound_keycode [POSITIONS];
  logic [31:0] last_tap [POSITIONS];
  logic        tap_down [POSITIONS];
  logic [15:0] hold_timer [POSITIONS];
  logic [15:0] rel_timer [POSITIONS];
  logic [31:0] now_ms;

  seq_t        sq, sq_next;
  in_item_t    cur;
  logic [SW-1:0] idx;
  logic [CW-1:0] cnt;
  out_item_t   res;
  seq_t        ret;   // where to resume after an emit

  logic [SW-1:0] pidx;
  logic          pos_ok;
  logic          walk_end;
  logic          cnt_full;
  logic [31:0]   since;

  assign pidx     = cur.position[SW-1:0];
  assign pos_ok   = ({24'd0, cur.position} < 32'(POSITIONS));
  assign walk_end = (32'(idx) == 32'(POSITIONS - 1));
  assign cnt_full = (32'(cnt) >= 32'(MAX_RESULTS));
  assign since    = now_ms - last_tap[pidx];

  // Lookahead for the "last" flag: any further emission in this tick.
  function automatic logic due_rel(input logic [SW-1:0] i);
    return tap_down[i] && rel_timer[i] <= 16'd1;
  endfunction
  function automatic logic due_hold(input logic [SW-1:0] i);
    return (key_state[i] == ST_PENDING || key_state[i] == ST_GRACE) &&
           hold_timer[i] <= 16'd1;
  endfunction

  // later emissions: any slot > idx.
  logic later_after_idx;
  always_comb begin
    later_after_idx = 1'b0;
    for (int i = 0; i < POSITIONS; i++) begin
      if (32'(i) > 32'(idx) && (due_rel(SW'(i)) || due_hold(SW'(i))))
        later_after_idx = 1'b1;
    end
  end

  assign in_ready  = (sq == SQ_IDLE);
  assign out_valid = (sq == SQ_EMIT);
  assign out_item  = res;

  always_comb begin
    sq_next = sq;
    unique case (sq)
      SQ_IDLE: if (in_valid) sq_next = SQ_KEY;
      SQ_KEY: begin
        sq_next = SQ_IDLE;
        if (cur.mode == MODE_TICK) sq_next = SQ_REL;
        else if (cur.mode == MODE_NONE) sq_next = SQ_IDLE;
        else if (!pos_ok) sq_next = SQ_EMIT;
        else if (cur.mode == MODE_RELEASE && key_state[pidx] == ST_PENDING &&
                 since >= {16'd0, cfg.cooldown}) sq_next = SQ_EMIT;
      end
      SQ_REL:  sq_next = (due_rel(idx) && !cnt_full) ? SQ_EMIT : SQ_HOLD;
      SQ_HOLD: begin
        if (due_hold(idx) && !cnt_full) sq_next = SQ_EMIT;
        else sq_next = walk_end ? SQ_IDLE : SQ_REL;
      end
      SQ_EMIT: if (out_ready) sq_next = ret;
      default: sq_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq <= SQ_IDLE;
      now_ms <= '0;
      idx <= '0;
      cnt <= '0;
      ret <= SQ_IDLE;
      for (int i = 0; i < POSITIONS; i++) begin
        key_state[i] <= ST_IDLE; bound_layer[i] <= '0; bound_keycode[i] <= '0;
        last_tap[i] <= '0; tap_down[i] <= 1'b0; hold_timer[i] <= '0;
        rel_timer[i] <= '0;
      end
    end else begin
      sq <= sq_next;
      unique case (sq)
        SQ_IDLE: if (in_valid) begin
          cur <= in_item;
          idx <= '0;
          cnt <= '0;
        end
        SQ_KEY: begin
          res.stamp <= now_ms; res.last <= 1'b1; res.layer_out <= '0;
          res.keycode_out <= '0; res.slot <= cur.position;
          if (cur.mode == MODE_TICK) begin
            now_ms <= now_ms + 32'd1;
          end else if (cur.mode == MODE_NONE) begin
          end else if (!pos_ok) begin
            res.kind <= K_REJECT; ret <= SQ_IDLE;
          end else if (cur.mode == MODE_PRESS) begin
            bound_layer[pidx] <= cur.layer;
            bound_keycode[pidx] <= cur.keycode;
            if (key_state[pidx] == ST_GRACE) begin
              hold_timer[pidx] <= '0; key_state[pidx] <= ST_HOLD;
            end else if (key_state[pidx] == ST_IDLE) begin
              key_state[pidx] <= ST_PENDING; hold_timer[pidx] <= cfg.term;
            end
          end else begin
            if (key_state[pidx] == ST_PENDING) begin
              hold_timer[pidx] <= '0; key_state[pidx] <= ST_IDLE;
              if (since >= {16'd0, cfg.cooldown}) begin
                last_tap[pidx] <= now_ms;
                if (!tap_down[pidx]) begin
                  tap_down[pidx] <= 1'b1; rel_timer[pidx] <= cfg.duration;
                end
                res.kind <= K_KEY_PRESS; res.keycode_out <= bound_keycode[pidx];
                ret <= SQ_IDLE;
              end
            end else if (key_state[pidx] == ST_HOLD) begin
              key_state[pidx] <= ST_GRACE; hold_timer[pidx] <= cfg.grace;
            end
          end
        end
        SQ_REL: begin
          res.stamp <= now_ms; res.slot <= 8'(idx);
          if (tap_down[idx]) begin
            if (rel_timer[idx] <= 16'd1) begin
              if (!cnt_full) begin
                tap_down[idx] <= 1'b0; rel_timer[idx] <= '0;
                res.kind <= K_KEY_RELEASE; res.layer_out <= '0;
                res.keycode_out <= bound_keycode[idx];
                res.last <= !((due_hold(idx) || later_after_idx) &&
                              (32'(cnt) + 32'd1 < 32'(MAX_RESULTS)));
                cnt <= cnt + 1'b1; ret <= SQ_HOLD;
              end else rel_timer[idx] <= 16'd1;
            end else rel_timer[idx] <= rel_timer[idx] - 16'd1;
          end
        end
        SQ_HOLD: begin
          res.stamp <= now_ms; res.slot <= 8'(idx);
          idx <= idx + 1'b1;
          if (key_state[idx] == ST_PENDING || key_state[idx] == ST_GRACE) begin
            if (hold_timer[idx] <= 16'd1) begin
              if (!cnt_full) begin
                hold_timer[idx] <= '0;
                key_state[idx] <= (key_state[idx] == ST_PENDING) ? ST_HOLD : ST_IDLE;
                res.kind <= (key_state[idx] == ST_PENDING) ? K_LAYER_ON : K_LAYER_OFF;
                res.layer_out <= bound_layer[idx]; res.keycode_out <= '0;
                res.last <= !(later_after_idx &&
                              (32'(cnt) + 32'd1 < 32'(MAX_RESULTS)));
                cnt <= cnt + 1'b1;
                ret <= walk_end ? SQ_IDLE : SQ_REL;
              end else hold_timer[idx] <= 16'd1;
            end else hold_timer[idx] <= hold_timer[idx] - 16'd1;
          end
        end
        SQ_EMIT: ;
        default: ;
      endcase
    end
  end
endmodule

### rtl/chatter_tolerant_hold_tap.sv
// chatter_tolerant_hold_tap: top level of the per-key hold-tap machine.
// Depends on cht_pkg, cht_regs, cht_core.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_ready | cht_pkg::in_item_t
//  out     | output    | out_valid/out_ready | cht_pkg::out_item_t
//  cfg     | input     | APB psel/penable | 32-bit registers at 4*i
//
// A press or release passes the key step and then one emit per result;
// a tick walks the slot table one half-slot per cycle (release check,
// then hold check), pausing for each emitted result and for stalls.
// The sequencer in cht_core serializes all slot updates.
// Reset (rst, synchronous) idles all slots and restores register defaults.
// Stalls on out hold the sequencer in place; no item is accepted meanwhile.
`timescale 1ns / 1ps
module chatter_tolerant_hold_tap #(
  parameter int POSITIONS = cht_pkg::POSITIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cht_pkg::in_item_t        in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cht_pkg::out_item_t       out_item,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [cht_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import cht_pkg::*;

  cfg_t cfg;

  assign pready = 1'b1;

  cht_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  cht_core #(.POSITIONS(POSITIONS)) u_core (
    .clk, .rst, .cfg, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item
  );
endmodule
